// ===== design/prq_pkg.sv =====
// Package for the priority ready queue: field widths, request and status codes,
// datapath command codes and the controller/datapath structs.
// No dependencies.
package prq_pkg;

   localparam int ACTION_W       = 2;
   localparam int QUEUE_ID_W     = 2;
   localparam int PROCESS_ID_W   = 5;
   localparam int PRIORITY_REQ_W = 8;
   localparam int RESULT_W       = 5;
   localparam int STATUS_W       = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INIT    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_IDLE         = 4'd0;
   localparam logic [OP_W-1:0] OP_CAPTURE      = 4'd1;
   localparam logic [OP_W-1:0] OP_FAIL_DUP     = 4'd2;
   localparam logic [OP_W-1:0] OP_FAIL_EMPTY   = 4'd3;
   localparam logic [OP_W-1:0] OP_FAIL_ABSENT  = 4'd4;
   localparam logic [OP_W-1:0] OP_INIT         = 4'd5;
   localparam logic [OP_W-1:0] OP_WALK_START   = 4'd6;
   localparam logic [OP_W-1:0] OP_WALK_STEP    = 4'd7;
   localparam logic [OP_W-1:0] OP_LINK_A       = 4'd8;
   localparam logic [OP_W-1:0] OP_LINK_B       = 4'd9;
   localparam logic [OP_W-1:0] OP_UNLINK_START = 4'd10;
   localparam logic [OP_W-1:0] OP_UNLINK_WR    = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } prq_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                member_hit;
      logic                first_is_proc;
      logic                walk_stop;
      logic                walk_next_proc;
   } prq_status_type;

endpackage

// ===== design/prq_req_if.sv =====
// Request channel: valid/ready handshake with the command fields.
// Depends on prq_pkg.
interface prq_req_if;
   logic                               valid;
   logic                               ready;
   logic [prq_pkg::ACTION_W-1:0]       action;
   logic [prq_pkg::QUEUE_ID_W-1:0]     queue_id;
   logic [prq_pkg::PROCESS_ID_W-1:0]   process_id;
   logic [prq_pkg::PRIORITY_REQ_W-1:0] priority_req;

   modport source(output valid, action, queue_id, process_id, priority_req, input ready);
   modport sink(input valid, action, queue_id, process_id, priority_req, output ready);
endinterface

// ===== design/prq_rsp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
// Depends on prq_pkg.
interface prq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [prq_pkg::RESULT_W-1:0] result_process;
   logic [prq_pkg::STATUS_W-1:0] status;

   modport source(output valid, result_process, status, input ready);
   modport sink(input valid, result_process, status, output ready);
endinterface

// ===== design/priority_ready_queue.sv =====
// Top level of the priority ready queue: controller plus datapath.
// Depends on prq_pkg, prq_req_if, prq_rsp_if, prq_controller, prq_datapath.
//
//   channel   dir  fields                                        handshake
//   req_chan  in   action, queue_id, process_id, priority_req    valid/ready
//   rsp_chan  out  result_process, status                        valid/ready
//
// One request at a time. Insert: decode, list walk, link update (LINK_A then
// LINK_B), response; one link-memory read per cycle during the walk.
// Dequeue and remove: decode and unlink read, unlink write, response;
// init and errors: decode, response. Reset is synchronous and needs no
// clearing pass; ready is held low until the response has been taken.
module priority_ready_queue #(
   parameter int NUM_PROCS      = 32,
   parameter int NUM_QUEUES     = 4,
   parameter int PRIORITY_WIDTH = 8
) (
   input logic       clock,
   input logic       reset,
   prq_req_if.sink   req_chan,
   prq_rsp_if.source rsp_chan
);

   prq_pkg::prq_cmd_type    cmd;
   prq_pkg::prq_status_type stat;

   prq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   prq_datapath #(
      .NUM_PROCS      (NUM_PROCS),
      .NUM_QUEUES     (NUM_QUEUES),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_chan.action),
      .req_queue_id       (req_chan.queue_id),
      .req_process_id     (req_chan.process_id),
      .req_priority_req   (req_chan.priority_req),
      .rsp_result_process (rsp_chan.result_process),
      .rsp_status         (rsp_chan.status)
   );

endmodule

// ===== design/prq_datapath.sv =====
// Datapath: link memories, priority memory, head/tail link registers,
// membership flags, walk pointers and the response register.
// Depends on prq_pkg.
module prq_datapath #(
   parameter int NUM_PROCS      = 32,
   parameter int NUM_QUEUES     = 4,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  prq_pkg::prq_cmd_type               cmd,
   output prq_pkg::prq_status_type            stat,
   input  logic [prq_pkg::ACTION_W-1:0]       req_action,
   input  logic [prq_pkg::QUEUE_ID_W-1:0]     req_queue_id,
   input  logic [prq_pkg::PROCESS_ID_W-1:0]   req_process_id,
   input  logic [prq_pkg::PRIORITY_REQ_W-1:0] req_priority_req,
   output logic [prq_pkg::RESULT_W-1:0]       rsp_result_process,
   output logic [prq_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int NODE_COUNT = NUM_PROCS + 2 * NUM_QUEUES;
   localparam int PW         = $clog2(NUM_PROCS);
   localparam int NW         = $clog2(NODE_COUNT);
   localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PID_VALUES = 1 << prq_pkg::PROCESS_ID_W;
   localparam int QID_VALUES = 1 << prq_pkg::QUEUE_ID_W;

   function automatic logic [NW-1:0] head_node(input logic [QW-1:0] q);
      head_node = NW'(NUM_PROCS) + NW'({q, 1'b0});
   endfunction

   function automatic logic [NW-1:0] tail_node(input logic [QW-1:0] q);
      tail_node = NW'(NUM_PROCS) + NW'({q, 1'b1});
   endfunction

   function automatic logic is_proc(input logic [NW-1:0] n);
      is_proc = (n < NW'(NUM_PROCS));
   endfunction

   logic [PW-1:0] proc_mod_tab [PID_VALUES];
   logic [QW-1:0] queue_mod_tab [QID_VALUES];

   for (genvar v = 0; v < PID_VALUES; v++) begin : g_pmod
      assign proc_mod_tab[v] = PW'(v % NUM_PROCS);
   end
   for (genvar v = 0; v < QID_VALUES; v++) begin : g_qmod
      assign queue_mod_tab[v] = QW'(v % NUM_QUEUES);
   end

   logic [prq_pkg::ACTION_W-1:0] action_ff;
   logic [QW-1:0]                q_ff;
   logic [PW-1:0]                p_ff;
   logic [PW-1:0]                tgt_ff;
   logic [PRIORITY_WIDTH-1:0]    pri_ff;
   logic [NW-1:0]                at_ff;
   logic [NW-1:0]                n_ff;
   logic [NW-1:0]                head_next_ff [NUM_QUEUES];
   logic [NW-1:0]                tail_prev_ff [NUM_QUEUES];
   logic                         mem_valid_ff [NUM_PROCS];
   logic [QW-1:0]                mem_queue_ff [NUM_PROCS];
   logic [prq_pkg::RESULT_W-1:0] result_ff;
   logic [prq_pkg::STATUS_W-1:0] status_ff;

   logic [NW-1:0]             next_mem [NUM_PROCS];
   logic [NW-1:0]             prev_mem [NUM_PROCS];
   logic [PRIORITY_WIDTH-1:0] pri_mem [NUM_PROCS];
   logic [NW-1:0]             next_rd_ff;
   logic [NW-1:0]             prev_rd_ff;
   logic [PRIORITY_WIDTH-1:0] pri_rd_ff;

   logic [NW-1:0] hn;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic          nx_we;
   logic [PW-1:0] nx_wa;
   logic [NW-1:0] nx_wd;
   logic          pv_we;
   logic [PW-1:0] pv_wa;
   logic [NW-1:0] pv_wd;
   logic          pr_we;

   assign hn = head_next_ff[q_ff];

   assign stat.action         = action_ff;
   assign stat.member_hit     = mem_valid_ff[p_ff];
   assign stat.first_is_proc  = is_proc(hn);
   assign stat.walk_stop      = (pri_rd_ff > pri_ff);
   assign stat.walk_next_proc = is_proc(next_rd_ff);

   assign rsp_result_process = result_ff;
   assign rsp_status         = status_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = p_ff;
      case (cmd.op)
         prq_pkg::OP_WALK_START: begin
            rd_en   = is_proc(hn);
            rd_addr = hn[PW-1:0];
         end
         prq_pkg::OP_WALK_STEP: begin
            rd_en   = is_proc(next_rd_ff);
            rd_addr = next_rd_ff[PW-1:0];
         end
         prq_pkg::OP_UNLINK_START: begin
            rd_en   = 1'b1;
            rd_addr = (action_ff == prq_pkg::ACT_DEQUEUE) ? hn[PW-1:0] : p_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      nx_we = 1'b0;
      nx_wa = p_ff;
      nx_wd = n_ff;
      pv_we = 1'b0;
      pv_wa = p_ff;
      pv_wd = at_ff;
      pr_we = 1'b0;
      case (cmd.op)
         prq_pkg::OP_LINK_A: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            pr_we = 1'b1;
         end
         prq_pkg::OP_LINK_B: begin
            nx_we = is_proc(at_ff);
            nx_wa = at_ff[PW-1:0];
            nx_wd = NW'(p_ff);
            pv_we = is_proc(n_ff);
            pv_wa = n_ff[PW-1:0];
            pv_wd = NW'(p_ff);
         end
         prq_pkg::OP_UNLINK_WR: begin
            nx_we = is_proc(prev_rd_ff);
            nx_wa = prev_rd_ff[PW-1:0];
            nx_wd = next_rd_ff;
            pv_we = is_proc(next_rd_ff);
            pv_wa = next_rd_ff[PW-1:0];
            pv_wd = prev_rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         next_rd_ff <= next_mem[rd_addr];
         prev_rd_ff <= prev_mem[rd_addr];
         pri_rd_ff  <= pri_mem[rd_addr];
      end
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
      if (pr_we) begin
         pri_mem[p_ff] <= pri_ff;
      end
   end

   // Head/tail links and queued flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_next_ff[q] <= tail_node(QW'(q));
            tail_prev_ff[q] <= head_node(QW'(q));
         end
         for (int i = 0; i < NUM_PROCS; i++) begin
            mem_valid_ff[i] <= 1'b0;
         end
      end else begin
         case (cmd.op)
            prq_pkg::OP_INIT: begin
               head_next_ff[q_ff] <= tail_node(q_ff);
               tail_prev_ff[q_ff] <= head_node(q_ff);
               for (int i = 0; i < NUM_PROCS; i++) begin
                  if (mem_queue_ff[i] == q_ff) begin
                     mem_valid_ff[i] <= 1'b0;
                  end
               end
            end
            prq_pkg::OP_LINK_A: begin
               if (!is_proc(at_ff)) begin
                  head_next_ff[q_ff] <= NW'(p_ff);
               end
               if (!is_proc(n_ff)) begin
                  tail_prev_ff[q_ff] <= NW'(p_ff);
               end
            end
            prq_pkg::OP_LINK_B: begin
               mem_valid_ff[p_ff] <= 1'b1;
            end
            prq_pkg::OP_UNLINK_WR: begin
               if (!is_proc(prev_rd_ff)) begin
                  head_next_ff[q_ff] <= next_rd_ff;
               end
               if (!is_proc(next_rd_ff)) begin
                  tail_prev_ff[q_ff] <= prev_rd_ff;
               end
               mem_valid_ff[tgt_ff] <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         prq_pkg::OP_CAPTURE: begin
            action_ff <= req_action;
            q_ff      <= queue_mod_tab[req_queue_id];
            p_ff      <= proc_mod_tab[req_process_id];
            pri_ff    <= PRIORITY_WIDTH'(req_priority_req);
         end
         prq_pkg::OP_FAIL_DUP: begin
            result_ff <= '0;
            status_ff <= prq_pkg::ST_DUP;
         end
         prq_pkg::OP_FAIL_EMPTY: begin
            result_ff <= '0;
            status_ff <= prq_pkg::ST_EMPTY;
         end
         prq_pkg::OP_FAIL_ABSENT: begin
            result_ff <= '0;
            status_ff <= prq_pkg::ST_ABSENT;
         end
         prq_pkg::OP_INIT: begin
            result_ff <= '0;
            status_ff <= prq_pkg::ST_OK;
         end
         prq_pkg::OP_WALK_START: begin
            at_ff <= head_node(q_ff);
            n_ff  <= hn;
         end
         prq_pkg::OP_WALK_STEP: begin
            if (!stat.walk_stop) begin
               at_ff <= n_ff;
               n_ff  <= next_rd_ff;
            end
         end
         prq_pkg::OP_LINK_B: begin
            mem_queue_ff[p_ff] <= q_ff;
            result_ff          <= prq_pkg::RESULT_W'(p_ff);
            status_ff          <= prq_pkg::ST_OK;
         end
         prq_pkg::OP_UNLINK_START: begin
            if (action_ff == prq_pkg::ACT_DEQUEUE) begin
               tgt_ff <= hn[PW-1:0];
            end else begin
               tgt_ff <= p_ff;
               q_ff   <= mem_queue_ff[p_ff];
            end
         end
         prq_pkg::OP_UNLINK_WR: begin
            result_ff <= prq_pkg::RESULT_W'(tgt_ff);
            status_ff <= prq_pkg::ST_OK;
         end
         default: begin
         end
      endcase
   end

   a_init_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.op == prq_pkg::OP_INIT |=>
         head_next_ff[$past(q_ff)] == tail_node($past(q_ff)))
      else $error("queue not empty after init");

   a_link_marks_member: assert property (@(posedge clock) disable iff (reset)
      cmd.op == prq_pkg::OP_LINK_B |=> mem_valid_ff[$past(p_ff)])
      else $error("inserted process not flagged as queued");

   a_unlink_clears_member: assert property (@(posedge clock) disable iff (reset)
      cmd.op == prq_pkg::OP_UNLINK_WR |=> !mem_valid_ff[$past(tgt_ff)])
      else $error("unlinked process still flagged as queued");

   a_fail_zero_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == prq_pkg::OP_FAIL_DUP || cmd.op == prq_pkg::OP_FAIL_EMPTY ||
       cmd.op == prq_pkg::OP_FAIL_ABSENT) |=> result_ff == '0)
      else $error("nonzero process on error status");

endmodule

// ===== design/prq_controller.sv =====
// Controller: sequences each request through decode, list walk, link update
// or unlink, and response. Depends on prq_pkg.
module prq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  prq_pkg::prq_status_type stat,
   output prq_pkg::prq_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_WALK      = 3'd2;
   localparam logic [2:0] S_LINK_A    = 3'd3;
   localparam logic [2:0] S_LINK_B    = 3'd4;
   localparam logic [2:0] S_UNLINK_WR = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd.op   = prq_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = prq_pkg::OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               prq_pkg::ACT_INSERT: begin
                  if (stat.member_hit) begin
                     cmd.op   = prq_pkg::OP_FAIL_DUP;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = prq_pkg::OP_WALK_START;
                     state_in = stat.first_is_proc ? S_WALK : S_LINK_A;
                  end
               end
               prq_pkg::ACT_DEQUEUE: begin
                  if (!stat.first_is_proc) begin
                     cmd.op   = prq_pkg::OP_FAIL_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = prq_pkg::OP_UNLINK_START;
                     state_in = S_UNLINK_WR;
                  end
               end
               prq_pkg::ACT_REMOVE: begin
                  if (!stat.member_hit) begin
                     cmd.op   = prq_pkg::OP_FAIL_ABSENT;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = prq_pkg::OP_UNLINK_START;
                     state_in = S_UNLINK_WR;
                  end
               end
               default: begin
                  cmd.op   = prq_pkg::OP_INIT;
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            cmd.op = prq_pkg::OP_WALK_STEP;
            if (stat.walk_stop || !stat.walk_next_proc) begin
               state_in = S_LINK_A;
            end
         end
         S_LINK_A: begin
            cmd.op   = prq_pkg::OP_LINK_A;
            state_in = S_LINK_B;
         end
         S_LINK_B: begin
            cmd.op   = prq_pkg::OP_LINK_B;
            state_in = S_RESP;
         end
         S_UNLINK_WR: begin
            cmd.op   = prq_pkg::OP_UNLINK_WR;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");

   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK_A |=> state_ff == S_LINK_B)
      else $error("link update split");

endmodule

// ===== bench/prq_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the design folder
// (prq_req_if, prq_rsp_if); this file holds the request and response records used by the bench.
// Depends on prq_pkg.
package prq_tb_pkg;

   typedef struct packed {
      logic [prq_pkg::ACTION_W-1:0]       action;
      logic [prq_pkg::QUEUE_ID_W-1:0]     queue_id;
      logic [prq_pkg::PROCESS_ID_W-1:0]   process_id;
      logic [prq_pkg::PRIORITY_REQ_W-1:0] priority_req;
   } prq_request_type;

   typedef struct packed {
      logic [prq_pkg::RESULT_W-1:0] result_process;
      logic [prq_pkg::STATUS_W-1:0] status;
   } prq_response_type;
endpackage

// ===== bench/priority_ready_queue_tb.sv =====
`timescale 1ns / 1ps
// Testbench for priority_ready_queue: directed and random queue commands,
// checked against a behavioral model of the linked ready queues.
// Depends on prq_pkg, prq_tb_pkg, prq_req_if, prq_rsp_if and the design.
module priority_ready_queue_tb;

   localparam int NPROC = 32;
   localparam int NQ    = 4;
   localparam int NNODE = NPROC + 2 * NQ;

   logic clock;
   logic reset;
   prq_req_if req_chan();
   prq_rsp_if rsp_chan();

   priority_ready_queue dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   int unsigned link_next[NNODE];
   int unsigned link_prev[NNODE];
   int unsigned proc_pri[NPROC];
   bit          queued[NPROC];
   int unsigned queued_in[NPROC];
   prq_tb_pkg::prq_response_type expected_rsp[$];

   int  errors;
   int  rsp_count;
   bit  hold_off;
   bit  idle_enable;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned head_node(int unsigned q);
      return NPROC + 2 * q;
   endfunction

   function automatic void queues_clear();
      for (int i = 0; i < NNODE; i++) begin
         link_next[i] = 0;
         link_prev[i] = 0;
      end
      for (int i = 0; i < NPROC; i++) begin
         queued[i] = 0;
         queued_in[i] = 0;
         proc_pri[i] = 0;
      end
      for (int q = 0; q < NQ; q++) begin
         link_next[head_node(q)] = head_node(q) + 1;
         link_prev[head_node(q) + 1] = head_node(q);
      end
   endfunction

   function automatic void unlink_proc(int unsigned p);
      int unsigned n;
      int unsigned v;
      n = link_next[p];
      v = link_prev[p];
      link_next[v] = n;
      link_prev[n] = v;
   endfunction

   function automatic prq_tb_pkg::prq_response_type queue_command(
         prq_tb_pkg::prq_request_type r);
      prq_tb_pkg::prq_response_type rsp;
      int unsigned q;
      int unsigned p;
      int unsigned at;
      int unsigned n;
      q = 32'(r.queue_id);
      p = 32'(r.process_id);
      rsp.result_process = '0;
      rsp.status = prq_pkg::ST_OK;
      case (r.action)
         prq_pkg::ACT_INSERT: begin
            if (queued[p]) begin
               rsp.status = prq_pkg::ST_DUP;
            end else begin
               at = head_node(q);
               for (int s = 0; s < NPROC; s++) begin
                  n = link_next[at];
                  if (n >= NPROC || proc_pri[n] > 32'(r.priority_req)) break;
                  at = n;
               end
               n = link_next[at];
               proc_pri[p] = 32'(r.priority_req);
               link_next[p] = n;
               link_prev[p] = at;
               link_prev[n] = p;
               link_next[at] = p;
               queued[p] = 1;
               queued_in[p] = q;
               rsp.result_process = prq_pkg::RESULT_W'(p);
            end
         end
         prq_pkg::ACT_DEQUEUE: begin
            n = link_next[head_node(q)];
            if (n >= NPROC) begin
               rsp.status = prq_pkg::ST_EMPTY;
            end else begin
               unlink_proc(n);
               queued[n] = 0;
               rsp.result_process = prq_pkg::RESULT_W'(n);
            end
         end
         prq_pkg::ACT_REMOVE: begin
            if (!queued[p]) begin
               rsp.status = prq_pkg::ST_ABSENT;
            end else begin
               unlink_proc(p);
               queued[p] = 0;
               rsp.result_process = prq_pkg::RESULT_W'(p);
            end
         end
         default: begin
            for (int i = 0; i < NPROC; i++)
               if (queued[i] && queued_in[i] == q) queued[i] = 0;
            link_next[head_node(q)] = head_node(q) + 1;
            link_prev[head_node(q) + 1] = head_node(q);
         end
      endcase
      return rsp;
   endfunction

   task automatic send_request(logic [1:0] act, logic [1:0] q, logic [4:0] p, logic [7:0] pri);
      prq_tb_pkg::prq_request_type r;
      r = {act, q, p, pri};
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 20) @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.action       <= act;
      req_chan.queue_id     <= q;
      req_chan.process_id   <= p;
      req_chan.priority_req <= pri;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_rsp.push_back(queue_command(r));
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || hold_off) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !(idle_enable && $urandom_range(99) < 20);
   end

   always @(posedge clock) begin
      prq_tb_pkg::prq_response_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response process=%0d status=%0d", $time,
                     rsp_chan.result_process, rsp_chan.status);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_chan.result_process !== want.result_process) begin
               errors++;
               $display("%0t: result_process expected %0d actual %0d", $time,
                        want.result_process, rsp_chan.result_process);
            end
            if (rsp_chan.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_chan.status);
            end
         end
      end
   end

   task automatic test_directed();
      send_request(prq_pkg::ACT_DEQUEUE, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_REMOVE, 2'd1, 5'd31, 8'd0);
      send_request(prq_pkg::ACT_INSERT, 2'd0, 5'd0, 8'd255);
      send_request(prq_pkg::ACT_INSERT, 2'd0, 5'd31, 8'd0);
      send_request(prq_pkg::ACT_INSERT, 2'd0, 5'd5, 8'd7);
      send_request(prq_pkg::ACT_INSERT, 2'd0, 5'd6, 8'd7);
      send_request(prq_pkg::ACT_INSERT, 2'd3, 5'd5, 8'd1);
      send_request(prq_pkg::ACT_INSERT, 2'd3, 5'd10, 8'd170);
      send_request(prq_pkg::ACT_INSERT, 2'd3, 5'd21, 8'd85);
      send_request(prq_pkg::ACT_REMOVE, 2'd0, 5'd6, 8'd0);
      send_request(prq_pkg::ACT_DEQUEUE, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_DEQUEUE, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_DEQUEUE, 2'd3, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_INIT, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_DEQUEUE, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_REMOVE, 2'd0, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_INIT, 2'd3, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_INSERT, 2'd3, 5'd10, 8'd3);
      send_request(prq_pkg::ACT_DEQUEUE, 2'd3, 5'd0, 8'd0);
      send_request(prq_pkg::ACT_INIT, 2'd2, 5'd31, 8'd255);
   endtask

   // responses held back at the start, queue 1 filled to the limit, then drained
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < NPROC; i++)
            send_request(prq_pkg::ACT_INSERT, 2'd1, i[4:0], 8'($urandom_range(3)));
      join
      for (int i = 0; i < NPROC; i++)
         send_request(prq_pkg::ACT_DEQUEUE, 2'd1, 5'd0, 8'd0);
   endtask

   task automatic test_random(int n, bit idle);
      int unsigned roll;
      idle_enable = idle;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 50)
            send_request(prq_pkg::ACT_INSERT, 2'($urandom), 5'($urandom),
                         ($urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom)));
         else if (roll < 72)
            send_request(prq_pkg::ACT_DEQUEUE, 2'($urandom), 5'($urandom), 8'($urandom));
         else if (roll < 96)
            send_request(prq_pkg::ACT_REMOVE, 2'($urandom), 5'($urandom), 8'($urandom));
         else
            send_request(prq_pkg::ACT_INIT, 2'($urandom), 5'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      errors = 0;
      rsp_count = 0;
      hold_off = 0;
      idle_enable = 1;
      reset = 1;
      req_chan.valid = 0;
      req_chan.action = prq_pkg::ACT_INSERT;
      req_chan.queue_id = '0;
      req_chan.process_id = '0;
      req_chan.priority_req = '0;
      queues_clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_backpressure();
      test_random(300, 1);
      test_random(200, 0);
      test_random(300, 1);
      wait_drained();
      repeat (50) @(negedge clock);
      $display("Covered insert, dequeue, remove and init with misuse cases, full queue");
      $display("under held-off responses; %0d responses checked.", rsp_count);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/prq_pkg.sv
design/prq_req_if.sv
design/prq_rsp_if.sv
design/prq_datapath.sv
design/prq_controller.sv
design/priority_ready_queue.sv
bench/prq_tb_if.sv
bench/priority_ready_queue_tb.sv
